>>> src/scsr_pkg.sv
// Shared types, command codes and sizes for the serial command SRAM responder.
package scsr_pkg;

  // Backup memory geometry
  localparam int ADDR_BITS = 16;
  localparam int MEM_DEPTH = 1 << ADDR_BITS;
  localparam logic [ADDR_BITS-1:0] ADDR_MASK = '1;
  // Sum width for address offset arithmetic (offsets reach 9 bits)
  localparam int SUM_W = ADDR_BITS + 2;

  // Request byte counter saturation and reply bounds
  localparam logic [8:0] POS_MAX           = 9'd511;
  localparam logic [8:0] REPLY_LIMIT_RESET = 9'd260;
  localparam logic [8:0] REPLY_MAX         = 9'd260;

  // Frame bytes
  localparam logic [7:0] SYNC_BYTE  = 8'h76;
  localparam logic [7:0] TAIL_FIRST = 8'h70;
  localparam logic [7:0] TAIL_LAST  = 8'h42;
  localparam logic [7:0] LEN_SHORT  = 8'h05;
  localparam logic [7:0] LEN_LONG   = 8'h06;

  // Command codes
  localparam logic [7:0] CMD_WRITE    = 8'hFA;
  localparam logic [7:0] CMD_READ     = 8'hFB;
  localparam logic [7:0] CMD_ECHO     = 8'hFE;
  localparam logic [7:0] CMD_SET_ADDR = 8'h01;
  localparam logic [7:0] CMD_CLR_ADDR = 8'h08;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_PUSH       = 2'd0,
    OP_PULL       = 2'd1,
    OP_CLEAR_FLAG = 2'd2,
    OP_NOP        = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_RESP
  } state_t;

  // Input item
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // Result item
  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_valid;
    logic       reply_last;
    logic [8:0] reply_length;
    logic       addressed;
  } result_t;

  // Memory port request
  typedef struct packed {
    logic                 we;
    logic [ADDR_BITS-1:0] addr;
    logic [7:0]           wdata;
  } mem_req_t;

endpackage

>>> src/scsr_ram.sv
// Generic single-port synchronous RAM with registered read data.
module scsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, read every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> src/scsr_engine.sv
// Command sequencer: packet parsing, reply generation and memory requests.
module scsr_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  scsr_pkg::item_t    item,
  input  logic               cfg_we,
  input  logic [8:0]         cfg_wdata,
  output logic               busy,
  output logic               done,
  output scsr_pkg::result_t  result,
  output scsr_pkg::mem_req_t mem_req,
  input  logic [7:0]         mem_rdata
);

  scsr_pkg::state_t state, state_next;

  // Architectural state
  logic [7:0]                     command_code, cmd_next;
  logic [8:0]                     byte_position, pos_next;
  logic [scsr_pkg::ADDR_BITS-1:0] start_address, addr_next;
  logic [7:0]                     transfer_count, cnt_next;
  logic                           echo_flag, echo_next;
  logic [8:0]                     reply_position, rpos_next;
  logic                           addressed_flag, flag_next;
  logic [8:0]                     reply_limit;
  logic [scsr_pkg::ADDR_BITS-1:0] clr_cnt;

  // Latched item and result staging
  scsr_pkg::item_t item_q;
  logic [7:0]      res_byte, byte_next;
  logic            res_valid, valid_next;
  logic            res_last, last_next;
  logic [8:0]      res_len, len_next;
  logic            res_from_mem, from_mem_next;

  // Memory access computed in the execute cycle
  logic                           wr_en;
  logic [scsr_pkg::ADDR_BITS-1:0] wr_addr, rd_addr;

  logic                           accept;
  logic                           clr_last;
  logic [8:0]                     cur_len, deliver, new_len, k_off, rd_off;
  logic [9:0]                     i_plus1, i_plus2;
  logic [15:0]                    hi_word, lo_word;
  logic [scsr_pkg::SUM_W-1:0]     clamp_sum, wr_sum, rd_sum;

  // Full reply length for a command
  function automatic logic [8:0] reply_len(input logic [7:0] cmd, input logic [7:0] cnt);
    logic [8:0] len;
    begin
      unique case (cmd)
        scsr_pkg::CMD_WRITE:    len = 9'(scsr_pkg::LEN_SHORT);
        scsr_pkg::CMD_READ:     len = 9'(scsr_pkg::LEN_SHORT) + 9'(cnt);
        scsr_pkg::CMD_ECHO:     len = 9'(scsr_pkg::LEN_LONG);
        scsr_pkg::CMD_SET_ADDR: len = 9'(scsr_pkg::LEN_LONG);
        default:                len = 9'd0;
      endcase
      return len;
    end
  endfunction

  assign accept   = start && !busy;
  assign clr_last = (clr_cnt == scsr_pkg::ADDR_MASK);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      scsr_pkg::ST_CLEAR: if (clr_last) state_next = scsr_pkg::ST_IDLE;
      scsr_pkg::ST_IDLE:  if (accept) state_next = scsr_pkg::ST_EXEC;
      scsr_pkg::ST_EXEC:  state_next = scsr_pkg::ST_RESP;
      scsr_pkg::ST_RESP: begin
        state_next = accept ? scsr_pkg::ST_EXEC : scsr_pkg::ST_IDLE;
      end
      default:            state_next = scsr_pkg::ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    busy = rst;
    done = 1'b0;
    unique case (state)
      scsr_pkg::ST_CLEAR: busy = 1'b1;
      scsr_pkg::ST_EXEC:  busy = 1'b1;
      scsr_pkg::ST_RESP:  done = 1'b1;
      default: ;
    endcase
  end

  // Execute one item against the current state
  always_comb begin
    cmd_next      = command_code;
    pos_next      = byte_position;
    addr_next     = start_address;
    cnt_next      = transfer_count;
    echo_next     = echo_flag;
    rpos_next     = reply_position;
    flag_next     = addressed_flag;
    byte_next     = 8'd0;
    valid_next    = 1'b0;
    last_next     = 1'b0;
    len_next      = 9'd0;
    from_mem_next = 1'b0;
    wr_en         = 1'b0;

    hi_word   = {item_q.data_byte, 8'h00};
    lo_word   = (16'(start_address) & 16'hFF00) | 16'(item_q.data_byte);
    clamp_sum = scsr_pkg::SUM_W'(start_address) + scsr_pkg::SUM_W'(item_q.data_byte);
    k_off     = byte_position - 9'd6;
    wr_sum    = scsr_pkg::SUM_W'(start_address) + scsr_pkg::SUM_W'(k_off);
    wr_addr   = wr_sum[scsr_pkg::ADDR_BITS-1:0];
    rd_off    = reply_position - 9'd3;
    rd_sum    = scsr_pkg::SUM_W'(start_address) + scsr_pkg::SUM_W'(rd_off);
    rd_addr   = rd_sum[scsr_pkg::ADDR_BITS-1:0];

    cur_len = reply_len(command_code, transfer_count);
    deliver = (cur_len > reply_limit) ? reply_limit : cur_len;
    i_plus1 = 10'(reply_position) + 10'd1;
    i_plus2 = 10'(reply_position) + 10'd2;
    new_len = 9'd0;

    unique case (item_q.opcode)
      scsr_pkg::OP_PUSH: begin
        // Drop header fields and any pending reply at packet start
        if (byte_position == 9'd0) begin
          cmd_next  = 8'd0;
          addr_next = '0;
          cnt_next  = 8'd0;
          echo_next = 1'b0;
          rpos_next = 9'd0;
        end
        priority if (byte_position == 9'd1) begin
          cmd_next = item_q.data_byte;
        end else if (byte_position == 9'd3) begin
          addr_next = hi_word[scsr_pkg::ADDR_BITS-1:0];
          echo_next = (item_q.data_byte != 8'd0);
        end else if (byte_position == 9'd4) begin
          addr_next = lo_word[scsr_pkg::ADDR_BITS-1:0];
        end else if (byte_position == 9'd5) begin
          // Clamp so the last byte touched stays below the top address
          if (clamp_sum >= scsr_pkg::SUM_W'(scsr_pkg::ADDR_MASK)) begin
            cnt_next = 8'(scsr_pkg::ADDR_MASK - start_address);
          end else begin
            cnt_next = item_q.data_byte;
          end
        end else if (byte_position >= 9'd6 && command_code == scsr_pkg::CMD_WRITE) begin
          wr_en = (k_off < 9'(transfer_count));
        end else begin
        end
        new_len = reply_len(cmd_next, cnt_next);
        if (item_q.last_byte) begin
          if (cmd_next == scsr_pkg::CMD_SET_ADDR) begin
            flag_next = 1'b1;
          end else if (cmd_next == scsr_pkg::CMD_CLR_ADDR) begin
            flag_next = 1'b0;
          end
          len_next  = new_len;
          rpos_next = 9'd0;
          pos_next  = 9'd0;
        end else begin
          pos_next = (byte_position < scsr_pkg::POS_MAX) ? byte_position + 9'd1
                                                         : scsr_pkg::POS_MAX;
        end
      end
      scsr_pkg::OP_PULL: begin
        if (byte_position == 9'd0 && reply_position < deliver) begin
          valid_next = 1'b1;
          last_next  = (i_plus1 == 10'(deliver));
          rpos_next  = reply_position + 9'd1;
          priority if (reply_position == 9'd0) begin
            byte_next = scsr_pkg::SYNC_BYTE;
          end else if (reply_position == 9'd1) begin
            byte_next = command_code;
          end else if (i_plus2 == 10'(cur_len)) begin
            byte_next = scsr_pkg::TAIL_FIRST;
          end else if (i_plus1 == 10'(cur_len)) begin
            byte_next = scsr_pkg::TAIL_LAST;
          end else begin
            unique case (command_code)
              scsr_pkg::CMD_WRITE: byte_next = scsr_pkg::LEN_SHORT;
              scsr_pkg::CMD_READ: begin
                if (reply_position == 9'd2) begin
                  byte_next = cur_len[7:0];
                end else begin
                  from_mem_next = 1'b1;
                end
              end
              scsr_pkg::CMD_ECHO: begin
                byte_next = (reply_position == 9'd2) ? scsr_pkg::LEN_LONG
                                                     : {7'd0, echo_flag};
              end
              default: begin
                byte_next = (reply_position == 9'd2) ? scsr_pkg::LEN_LONG : 8'd0;
              end
            endcase
          end
        end
      end
      scsr_pkg::OP_CLEAR_FLAG: flag_next = 1'b0;
      default: ;
    endcase
  end

  // Drive the memory port: clearing sweep, item write, or reply read
  always_comb begin
    mem_req.we    = 1'b0;
    mem_req.addr  = rd_addr;
    mem_req.wdata = item_q.data_byte;
    if (state == scsr_pkg::ST_CLEAR) begin
      mem_req.we    = 1'b1;
      mem_req.addr  = clr_cnt;
      mem_req.wdata = 8'd0;
    end else if (state == scsr_pkg::ST_EXEC && wr_en) begin
      mem_req.we   = 1'b1;
      mem_req.addr = wr_addr;
    end
  end

  // Present the staged result, memory bytes straight from the read port
  always_comb begin
    result.reply_byte   = res_from_mem ? mem_rdata : res_byte;
    result.reply_valid  = res_valid;
    result.reply_last   = res_last;
    result.reply_length = res_len;
    result.addressed    = addressed_flag;
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= scsr_pkg::ST_CLEAR;
      clr_cnt        <= '0;
      command_code   <= 8'd0;
      byte_position  <= 9'd0;
      start_address  <= '0;
      transfer_count <= 8'd0;
      echo_flag      <= 1'b0;
      reply_position <= 9'd0;
      addressed_flag <= 1'b0;
      reply_limit    <= scsr_pkg::REPLY_LIMIT_RESET;
    end else begin
      state <= state_next;
      if (state == scsr_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (cfg_we) begin
        reply_limit <= cfg_wdata;
      end
      if (state == scsr_pkg::ST_EXEC) begin
        command_code   <= cmd_next;
        byte_position  <= pos_next;
        start_address  <= addr_next;
        transfer_count <= cnt_next;
        echo_flag      <= echo_next;
        reply_position <= rpos_next;
        addressed_flag <= flag_next;
      end
    end
  end

  // Item capture and result staging
  always_ff @(posedge clk) begin
    if (accept) begin
      item_q <= item;
    end
    if (state == scsr_pkg::ST_EXEC) begin
      res_byte     <= byte_next;
      res_valid    <= valid_next;
      res_last     <= last_next;
      res_len      <= len_next;
      res_from_mem <= from_mem_next;
    end
  end

  // Every executed item yields a result in the next cycle
  a_exec_then_done: assert property (@(posedge clk) disable iff (rst)
    state == scsr_pkg::ST_EXEC |=> done)
    else $error("execute cycle not followed by a result");

  // Item writes happen only for a write command
  a_write_cmd: assert property (@(posedge clk) disable iff (rst)
    (mem_req.we && state == scsr_pkg::ST_EXEC) |-> command_code == scsr_pkg::CMD_WRITE)
    else $error("memory write outside a write command");

  // A last reply byte is always a real byte
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    (done && result.reply_last) |-> result.reply_valid)
    else $error("reply_last without reply_valid");

  // Reply position never passes the longest reply
  a_rpos_bound: assert property (@(posedge clk) disable iff (rst)
    reply_position <= scsr_pkg::REPLY_MAX)
    else $error("reply position beyond longest reply");

  // Clearing sweep runs to the top address before releasing the block
  a_clear_full: assert property (@(posedge clk) disable iff (rst)
    (state == scsr_pkg::ST_CLEAR && !clr_last) |=> state == scsr_pkg::ST_CLEAR)
    else $error("clearing sweep ended early");

endmodule

>>> src/serial_command_sram_responder_core.sv
// Top level: backup memory and command sequencer of the serial responder.
// Flow: an accepted item is captured and executed in the execute state; done rises in the
//   response state, where the result and the registered backup memory read are presented.
//   A new item is taken in the response state, not during execute; results cannot be stalled.
// Reset: state and control registers clear at once, then a clearing sweep zeroes the
//   65536-byte memory, one byte a cycle, with busy high.
module serial_command_sram_responder_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  scsr_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  output logic              done,
  output scsr_pkg::result_t result
);

  scsr_pkg::mem_req_t mem_req;
  logic [7:0]         mem_rdata;

  // Byte-wide backup memory
  scsr_ram #(
    .WIDTH (8),
    .DEPTH (scsr_pkg::MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .addr  (mem_req.addr),
    .wdata (mem_req.wdata),
    .rdata (mem_rdata)
  );

  // Packet parser and reply sequencer
  scsr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

endmodule
